>>> src/npc_pkg.sv
// Shared types and constants for the nearest palette color search.
// Used by the controller, the datapath and the top level; no dependencies.
package npc_pkg;

   // request opcodes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // field widths fixed by the interface
   localparam int CHAN_W   = 8;
   localparam int INDEX_W  = 8;
   localparam int SIZE_W   = 9;
   localparam int ENTRY_W  = 3 * CHAN_W;
   localparam int SQ_W     = 2 * CHAN_W;
   localparam int DIST_W   = SQ_W + 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_PALETTE_SIZE = 1'b0;

   // commands from the controller to the datapath
   typedef struct packed {
      logic write;
      logic load;
      logic step;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic size_zero;
      logic last;
      logic pipe_busy;
   } status_type;

endpackage

>>> src/npc_datapath.sv
// Datapath: palette memory, scan address counter, distance pipeline and best tracker.
// Depends on npc_pkg for field widths and the command and status structs.
module npc_datapath #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  npc_pkg::cmd_type                cmd,
   output npc_pkg::status_type             status,
   input  logic [npc_pkg::SIZE_W-1:0]      palette_size,
   input  logic [npc_pkg::INDEX_W-1:0]     entry_index,
   input  logic [npc_pkg::CHAN_W-1:0]      red,
   input  logic [npc_pkg::CHAN_W-1:0]      green,
   input  logic [npc_pkg::CHAN_W-1:0]      blue,
   output logic [npc_pkg::INDEX_W-1:0]     nearest_index
);

   localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [npc_pkg::SIZE_W-1:0] DEPTH_SZ = npc_pkg::SIZE_W'(PALETTE_DEPTH);

   // palette memory
   logic [npc_pkg::ENTRY_W-1:0] mem [PALETTE_DEPTH];

   logic [IDX_W-1:0]              addr_ff, addr_in;
   logic [npc_pkg::CHAN_W-1:0]    qr_ff, qg_ff, qb_ff;
   logic [npc_pkg::ENTRY_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]              rd_idx_ff, sq_idx_ff;
   logic                          rd_valid_ff, sq_valid_ff;
   logic [npc_pkg::SQ_W-1:0]      sq_r_ff, sq_g_ff, sq_b_ff;
   logic [npc_pkg::SQ_W-1:0]      sq_r_in, sq_g_in, sq_b_in;
   logic [npc_pkg::DIST_W-1:0]    dist_sum, best_dist_ff;
   logic [IDX_W-1:0]              best_ff;
   logic                          have_ff;
   logic [npc_pkg::SIZE_W-1:0]    count;
   logic                          in_range;

   // clip the searched size to the depth
   always_comb begin
      count = (palette_size > DEPTH_SZ) ? DEPTH_SZ : palette_size;
   end

   assign in_range = ({1'b0, entry_index} < DEPTH_SZ);

   // start at the highest searched index, walk down one entry a cycle
   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = IDX_W'(count - npc_pkg::SIZE_W'(1));
      end else if (cmd.step) begin
         addr_in = addr_ff - IDX_W'(1);
      end
   end

   // write and registered read of the palette
   always_ff @(posedge clock) begin
      if (cmd.write && in_range) begin
         mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
      end
      if (cmd.step) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // squared channel differences
   function automatic logic [npc_pkg::SQ_W-1:0] sq_diff(
      input logic [npc_pkg::CHAN_W-1:0] a,
      input logic [npc_pkg::CHAN_W-1:0] b
   );
      logic [npc_pkg::CHAN_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return npc_pkg::SQ_W'(d) * npc_pkg::SQ_W'(d);
   endfunction

   always_comb begin
      sq_r_in = sq_diff(qr_ff, rd_data_ff[23:16]);
      sq_g_in = sq_diff(qg_ff, rd_data_ff[15:8]);
      sq_b_in = sq_diff(qb_ff, rd_data_ff[7:0]);
      dist_sum = npc_pkg::DIST_W'(sq_r_ff) + npc_pkg::DIST_W'(sq_g_ff)
               + npc_pkg::DIST_W'(sq_b_ff);
   end

   // payload stages
   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;
      sq_idx_ff <= rd_idx_ff;
      sq_r_ff   <= sq_r_in;
      sq_g_ff   <= sq_g_in;
      sq_b_ff   <= sq_b_in;
      if (cmd.load) begin
         qr_ff <= red;
         qg_ff <= green;
         qb_ff <= blue;
      end
   end

   // pipeline valids and best tracker; take a new best only on a strictly smaller distance
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
         best_ff     <= '0;
      end else begin
         rd_valid_ff <= cmd.step;
         sq_valid_ff <= rd_valid_ff;
         if (cmd.load) begin
            have_ff <= 1'b0;
            best_ff <= '0;
         end else if (sq_valid_ff && (!have_ff || dist_sum < best_dist_ff)) begin
            have_ff <= 1'b1;
            best_ff <= sq_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_valid_ff && (!have_ff || dist_sum < best_dist_ff)) begin
         best_dist_ff <= dist_sum;
      end
   end

   assign status.size_zero = (count == '0);
   assign status.last      = (addr_ff == '0);
   assign status.pipe_busy = rd_valid_ff | sq_valid_ff;
   assign nearest_index    = npc_pkg::INDEX_W'(best_ff);

endmodule

>>> src/npc_ctrl.sv
// Controller: sequences write, scan and drain phases and raises the result strobe.
// Depends on npc_pkg for opcodes and the command and status structs.
module npc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 op,
   output logic                 busy,
   output logic                 rsp_valid,
   output npc_pkg::cmd_type     cmd,
   input  npc_pkg::status_type  status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op == npc_pkg::OP_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  if (status.size_zero) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !status.pipe_busy)
      else $error("distance pipeline active while idle");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while a scan is running");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(op) == npc_pkg::OP_QUERY)
      else $error("scan began without a query request");
`endif

endmodule

>>> src/nearest_palette_color.sv
// Nearest palette color search: APB register, controller and datapath.
// Depends on npc_pkg, npc_ctrl and npc_datapath. A query over
// n = min(palette_size, PALETTE_DEPTH) > 0 entries scans with one palette memory
// read per cycle, then drains the distance pipeline and strobes its result;
// with n = 0 the result is strobed without a scan. Reset clears control and palette_size;
// palette contents stay undefined until written.
module nearest_palette_color #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic [npc_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [npc_pkg::CHAN_W-1:0]        req_red,
   input  logic [npc_pkg::CHAN_W-1:0]        req_green,
   input  logic [npc_pkg::CHAN_W-1:0]        req_blue,
   // result channel
   output logic                              rsp_valid,
   output logic [npc_pkg::INDEX_W-1:0]       rsp_nearest_index,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [npc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [npc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [npc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   logic [npc_pkg::SIZE_W-1:0] palette_size_ff, palette_size_in;
   npc_pkg::cmd_type           cmd;
   npc_pkg::status_type        status;
   logic                       reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == npc_pkg::REG_PALETTE_SIZE);

   // write the size register on the access phase
   always_comb begin
      palette_size_in = palette_size_ff;
      if (psel && penable && pwrite && reg_sel) begin
         palette_size_in = pwdata[npc_pkg::SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= '0;
      end else begin
         palette_size_ff <= palette_size_in;
      end
   end

   // read back
   assign prdata = reg_sel ? npc_pkg::CSR_DATA_W'(palette_size_ff) : '0;

   npc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_op),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   npc_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .palette_size  (palette_size_ff),
      .entry_index   (req_entry_index),
      .red           (req_red),
      .green         (req_green),
      .blue          (req_blue),
      .nearest_index (rsp_nearest_index)
   );

endmodule

>>> dv/nearest_palette_color_tb.sv
// Self-checking testbench for the nearest palette color search block.
// Drives palette writes and color queries, predicts each nearest index, programs
// palette_size over APB; depends on npc_pkg and nearest_palette_color.
`timescale 1ns / 1ps

module nearest_palette_color_tb;

   localparam int PALETTE_DEPTH = 256;
   localparam int CLK_PERIOD    = 10;
   // settle time after the last result: covers a pending write and a full scan
   localparam int WRITE_SETTLE  = 8;
   localparam int SCAN_LATENCY  = PALETTE_DEPTH + 8;
   localparam int END_WAIT      = 4 * SCAN_LATENCY;
   localparam int RUN_LIMIT_NS  = 60_000_000;

   // register byte addresses
   localparam logic [npc_pkg::CSR_ADDR_W-1:0] ADDR_PALETTE_SIZE =
      npc_pkg::CSR_ADDR_W'(4 * npc_pkg::REG_PALETTE_SIZE);
   localparam logic [npc_pkg::CSR_ADDR_W-1:0] ADDR_UNUSED = npc_pkg::CSR_ADDR_W'(4);

   typedef struct packed {
      logic [npc_pkg::CHAN_W-1:0] red;
      logic [npc_pkg::CHAN_W-1:0] green;
      logic [npc_pkg::CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct {
      rgb_type                      color;
      logic [npc_pkg::INDEX_W-1:0]  nearest;
   } pending_query_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic                              req_op;
   logic [npc_pkg::INDEX_W-1:0]       req_entry_index;
   logic [npc_pkg::CHAN_W-1:0]        req_red;
   logic [npc_pkg::CHAN_W-1:0]        req_green;
   logic [npc_pkg::CHAN_W-1:0]        req_blue;
   logic                              rsp_valid;
   logic [npc_pkg::INDEX_W-1:0]       rsp_nearest_index;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [npc_pkg::CSR_ADDR_W-1:0]    paddr;
   logic [npc_pkg::CSR_DATA_W-1:0]    pwdata;
   logic [npc_pkg::CSR_DATA_W-1:0]    prdata;
   logic                              pready;

   // predictor state: palette copy and register copy
   rgb_type                           palette_model [PALETTE_DEPTH];
   logic [npc_pkg::SIZE_W-1:0]        size_model;
   pending_query_type                 pending_nearest_q [$];
   int unsigned                       error_count;
   bit                                gaps_enabled;

   nearest_palette_color #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_entry_index   (req_entry_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_nearest_index (rsp_nearest_index),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // hard stop for a hung run
   initial begin
      #(RUN_LIMIT_NS);
      $display("[nearest_palette_color] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int searched_entries();
      return (size_model > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size_model);
   endfunction

   // scan from the top down, take a new best only on a strictly smaller distance
   function automatic logic [npc_pkg::INDEX_W-1:0] nearest_entry_index(input rgb_type color);
      int n;
      int dr, dg, db;
      int dist_sum;
      int best_dist;
      logic [npc_pkg::INDEX_W-1:0] best;
      n = searched_entries();
      best = '0;
      best_dist = -1;
      for (int i = n - 1; i >= 0; i--) begin
         dr = int'(color.red) - int'(palette_model[i].red);
         dg = int'(color.green) - int'(palette_model[i].green);
         db = int'(color.blue) - int'(palette_model[i].blue);
         dist_sum = dr * dr + dg * dg + db * db;
         if (best_dist < 0 || dist_sum < best_dist) begin
            best = npc_pkg::INDEX_W'(i);
            best_dist = dist_sum;
         end
      end
      return best;
   endfunction

   // compare each strobed result with the oldest pending query
   always @(posedge clock) begin
      pending_query_type head;
      if (!reset && rsp_valid) begin
         if (pending_nearest_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result index %0d", rsp_nearest_index));
         end else begin
            head = pending_nearest_q.pop_front();
            if (rsp_nearest_index !== head.nearest)
               report_mismatch($sformatf("query %02h%02h%02h: index %0d, expected %0d",
                  head.color.red, head.color.green, head.color.blue,
                  rsp_nearest_index, head.nearest));
         end
      end
   end

   // one request; entered and left at a falling edge, start is left high
   task automatic send_request(input logic op, input logic [npc_pkg::INDEX_W-1:0] index,
                               input rgb_type color);
      pending_query_type q;
      start           <= 1'b1;
      req_op          <= op;
      req_entry_index <= index;
      req_red         <= color.red;
      req_green       <= color.green;
      req_blue        <= color.blue;
      do @(posedge clock); while (busy);
      // accepted at this edge: update the predictor in request order
      if (op == npc_pkg::OP_QUERY) begin
         q.color = color;
         q.nearest = nearest_entry_index(color);
         pending_nearest_q.push_back(q);
      end else begin
         palette_model[index] = color;
      end
      @(negedge clock);
   endtask

   // random sender idle burst
   task automatic sender_gap();
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   // hold off until every result is in and the block has gone idle
   task automatic drain_results();
      start <= 1'b0;
      while (pending_nearest_q.size() != 0) @(negedge clock);
      do @(posedge clock); while (busy);
      repeat (WRITE_SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_transfer(input logic write_en,
                               input logic [npc_pkg::CSR_ADDR_W-1:0] addr,
                               input logic [npc_pkg::CSR_DATA_W-1:0] wdata,
                               output logic [npc_pkg::CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_en;
      paddr   <= addr;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_size_readback();
      logic [npc_pkg::CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b0, ADDR_PALETTE_SIZE, '0, rdata);
      if (rdata !== npc_pkg::CSR_DATA_W'(size_model))
         report_mismatch($sformatf("palette_size reads %0h, expected %0h", rdata, size_model));
   endtask

   // only the low nine bits of the write data land in the register
   task automatic program_palette_size(input logic [npc_pkg::CSR_DATA_W-1:0] value);
      logic [npc_pkg::CSR_DATA_W-1:0] rdata;
      drain_results();
      csr_transfer(1'b1, ADDR_PALETTE_SIZE, value, rdata);
      size_model = value[npc_pkg::SIZE_W-1:0];
      check_size_readback();
   endtask

   // a write to an unmapped register must leave palette_size alone
   task automatic write_unused_register(input logic [npc_pkg::CSR_DATA_W-1:0] value);
      logic [npc_pkg::CSR_DATA_W-1:0] rdata;
      drain_results();
      csr_transfer(1'b1, ADDR_UNUSED, value, rdata);
      check_size_readback();
   endtask

   function automatic logic [npc_pkg::CHAN_W-1:0] random_channel();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return npc_pkg::CHAN_W'($urandom);
      endcase
   endfunction

   function automatic logic [npc_pkg::CHAN_W-1:0] nudge_channel(
      input logic [npc_pkg::CHAN_W-1:0] c
   );
      int v;
      v = int'(c) + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return npc_pkg::CHAN_W'(v);
   endfunction

   // entry colors: duplicates of other entries make ties likely
   function automatic rgb_type pick_entry_color();
      rgb_type c;
      case ($urandom_range(0, 2))
         0:       c = palette_model[$urandom_range(0, PALETTE_DEPTH - 1)];
         1:       c = rgb_type'(npc_pkg::ENTRY_W'($urandom));
         default: c = '{random_channel(), random_channel(), random_channel()};
      endcase
      return c;
   endfunction

   // query colors: exact hits, near misses, random and corner colors
   function automatic rgb_type pick_query_color();
      rgb_type c;
      int n;
      n = searched_entries();
      c = palette_model[$urandom_range(0, (n > 0) ? n - 1 : 0)];
      case ($urandom_range(0, 4))
         0:       ;
         1:       c = '{nudge_channel(c.red), nudge_channel(c.green), nudge_channel(c.blue)};
         2, 3:    c = rgb_type'(npc_pkg::ENTRY_W'($urandom));
         default: c = '{random_channel(), random_channel(), random_channel()};
      endcase
      return c;
   endfunction

   // empty palette: every query returns index zero
   task automatic test_empty_palette();
      check_size_readback();
      send_request(npc_pkg::OP_QUERY, 8'h00, '{8'hFF, 8'hFF, 8'hFF});
      // bit 9 and above are dropped, so this writes zero
      program_palette_size(32'hFFFF_FE00);
      send_request(npc_pkg::OP_QUERY, 8'hFF, '{8'h00, 8'h00, 8'h00});
   endtask

   // a few hand-placed entries: exact match, tie to the higher index, extremes
   task automatic test_small_palette();
      send_request(npc_pkg::OP_WRITE, 8'd0, '{8'h00, 8'h00, 8'h00});
      send_request(npc_pkg::OP_WRITE, 8'd1, '{8'hFF, 8'hFF, 8'hFF});
      send_request(npc_pkg::OP_WRITE, 8'd2, '{8'hFF, 8'h00, 8'h80});
      send_request(npc_pkg::OP_WRITE, 8'd3, '{8'hFF, 8'hFF, 8'hFF});
      send_request(npc_pkg::OP_WRITE, 8'd255, '{8'h01, 8'h02, 8'h03});
      program_palette_size(32'd4);
      send_request(npc_pkg::OP_QUERY, 8'd7, '{8'hFF, 8'hFF, 8'hFF});
      send_request(npc_pkg::OP_QUERY, 8'd0, '{8'h00, 8'h00, 8'h00});
      send_request(npc_pkg::OP_QUERY, 8'd2, '{8'hFF, 8'h00, 8'h80});
      send_request(npc_pkg::OP_QUERY, 8'd9, '{8'hC8, 8'h0A, 8'h64});
      send_request(npc_pkg::OP_QUERY, 8'd1, '{8'h80, 8'h80, 8'h80});
      send_request(npc_pkg::OP_QUERY, 8'd3, '{8'h00, 8'hFF, 8'hFF});
      program_palette_size(32'd1);
      send_request(npc_pkg::OP_QUERY, 8'd0, '{8'hFF, 8'hFF, 8'hFF});
      write_unused_register(32'h0000_0003);
      send_request(npc_pkg::OP_QUERY, 8'd0, '{8'hFF, 8'hFF, 8'hFF});
      program_palette_size(32'd2);
      send_request(npc_pkg::OP_QUERY, 8'd0, '{8'hFF, 8'hFF, 8'hFF});
   endtask

   // write every entry so any size may be searched from here on
   task automatic test_fill_palette();
      gaps_enabled = 1'b1;
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
         sender_gap();
         send_request(npc_pkg::OP_WRITE, npc_pkg::INDEX_W'(i), pick_entry_color());
      end
   endtask

   // full depth and sizes beyond it search all entries; a size one below leaves out the top entry
   task automatic test_size_saturation();
      program_palette_size(32'd256);
      send_request(npc_pkg::OP_QUERY, 8'h00, pick_query_color());
      send_request(npc_pkg::OP_QUERY, 8'hA5, '{8'h00, 8'h00, 8'h00});
      program_palette_size(32'd511);
      send_request(npc_pkg::OP_QUERY, 8'h5A, pick_query_color());
      send_request(npc_pkg::OP_QUERY, 8'hFF, '{8'hFF, 8'hFF, 8'hFF});
      program_palette_size(32'd257);
      send_request(npc_pkg::OP_QUERY, 8'h11, pick_query_color());
      program_palette_size(32'd255);
      send_request(npc_pkg::OP_QUERY, 8'h22, palette_model[PALETTE_DEPTH - 1]);
   endtask

   // phases of random requests, each under a fresh palette_size
   task automatic test_random_traffic(input int unsigned item_goal, input bit allow_gaps);
      int unsigned items_sent;
      int unsigned phase_items;
      int unsigned pause_at;
      int unsigned sel;
      int n;
      logic [npc_pkg::SIZE_W-1:0] size_pick;
      logic [npc_pkg::CSR_DATA_W-1:0] junk;
      bit first_phase;
      bit big_size;
      items_sent = 0;
      first_phase = 1'b1;
      while (items_sent < item_goal) begin
         // mostly small palettes; a few full or oversized ones
         sel = $urandom_range(0, 19);
         big_size = (sel == 1 || sel == 2);
         case (sel)
            0:       size_pick = '0;
            1:       size_pick = npc_pkg::SIZE_W'($urandom_range(255, 256));
            2:       size_pick = npc_pkg::SIZE_W'($urandom_range(257, 511));
            3, 4, 5: size_pick = npc_pkg::SIZE_W'($urandom_range(17, 64));
            default: size_pick = npc_pkg::SIZE_W'($urandom_range(1, 16));
         endcase
         junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FE00) : '0;
         program_palette_size(junk | npc_pkg::CSR_DATA_W'(size_pick));
         if ($urandom_range(0, 7) == 0)
            write_unused_register($urandom);
         n = searched_entries();
         gaps_enabled = allow_gaps && ($urandom_range(0, 3) != 0);
         phase_items = big_size ? $urandom_range(4, 12) : $urandom_range(20, 60);
         pause_at = (allow_gaps && (first_phase || $urandom_range(0, 2) == 0))
                    ? phase_items / 2 : phase_items + 1;
         first_phase = 1'b0;
         for (int unsigned k = 0; k < phase_items; k++) begin
            if (k == pause_at)
               drain_results();
            sender_gap();
            if ($urandom_range(0, 9) < 6)
               send_request(npc_pkg::OP_QUERY, npc_pkg::INDEX_W'($urandom),
                            pick_query_color());
            else if (n > 0 && $urandom_range(0, 2) != 0)
               send_request(npc_pkg::OP_WRITE, npc_pkg::INDEX_W'($urandom_range(0, n - 1)),
                            pick_entry_color());
            else
               send_request(npc_pkg::OP_WRITE, npc_pkg::INDEX_W'($urandom),
                            pick_entry_color());
            items_sent++;
         end
      end
   endtask

   initial begin
      int unsigned wait_cycles;
      reset           = 1'b1;
      start           = 1'b0;
      req_op          = npc_pkg::OP_WRITE;
      req_entry_index = '0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      size_model      = '0;
      error_count     = 0;
      gaps_enabled    = 1'b0;
      for (int i = 0; i < PALETTE_DEPTH; i++) palette_model[i] = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_palette();
      test_small_palette();
      test_fill_palette();
      test_size_saturation();
      test_random_traffic(1400, 1'b1);
      test_random_traffic(220, 1'b0);

      // wait out the last results, then watch for stray strobes
      start <= 1'b0;
      for (wait_cycles = 0; wait_cycles < END_WAIT && pending_nearest_q.size() != 0;
           wait_cycles++)
         @(posedge clock);
      repeat (SCAN_LATENCY) @(posedge clock);
      if (pending_nearest_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_nearest_q.size()));

      if (error_count == 0) begin
         $display("[nearest_palette_color] OK");
      end else begin
         $display("[nearest_palette_color] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/npc_pkg.sv
src/npc_datapath.sv
src/npc_ctrl.sv
src/nearest_palette_color.sv
dv/nearest_palette_color_tb.sv
